>>> rtl/lae_pkg.sv
// Shared types, constants and the B3/S23 row rule for the life automaton engine.
// No dependencies; imported by lae_ctrl, lae_dpath, life_automaton_engine_unit, testbench.
package lae_pkg;

	// Board geometry
	localparam int MAX_COLS = 64;
	localparam int MAX_ROWS = 64;
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int CFG_W    = 7;
	localparam int GEN_W    = 16;
	// Sweep counter runs 0 .. MAX_ROWS + 1 (one read lead-in, one flush)
	localparam int K_W      = $clog2(MAX_ROWS + 2);
	localparam logic [K_W-1:0] SWEEP_LAST = K_W'(MAX_ROWS + 1);

	// Register reset and clamp limits
	localparam logic [CFG_W-1:0] CFG_RST   = CFG_W'(64);
	localparam logic [CFG_W-1:0] DIM_MIN   = CFG_W'(3);
	localparam logic [CFG_W-1:0] COLS_LIM  = CFG_W'(MAX_COLS);
	localparam logic [CFG_W-1:0] ROWS_LIM  = CFG_W'(MAX_ROWS);

	// Register indexes
	localparam logic CFG_IDX_WIDTH  = 1'b0;
	localparam logic CFG_IDX_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_RUN   = 2'd1,
		OP_READ  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_SWEEP
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic             rd_sweep;   // read address from sweep counter
		logic [ROW_W-1:0] sweep_row;
		logic             clear;      // zero the row window
		logic             shift;      // advance the row window
		logic             wb_en;      // write back a computed row
		logic [ROW_W-1:0] wb_row;
		logic             dn_zero;    // lower neighbor is past the last row
		logic             cell_wr;    // single cell write item
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic changed;  // some row differed in the current generation
		logic rd_cell;  // cell value for the item read last cycle
	} stat_t;

	// B3/S23 over one row, given the live rows above, at and below
	function automatic logic [MAX_COLS-1:0] life_next(
		input logic [MAX_COLS-1:0] up,
		input logic [MAX_COLS-1:0] mid,
		input logic [MAX_COLS-1:0] dn
	);
		logic [MAX_COLS-1:0] ul, ur, ml, mr, dl, dr, nx;
		logic [3:0]          n;
		ul = up << 1;
		ur = up >> 1;
		ml = mid << 1;
		mr = mid >> 1;
		dl = dn << 1;
		dr = dn >> 1;
		for (int c = 0; c < MAX_COLS; c++) begin
			n = 4'(ul[c]) + 4'(up[c]) + 4'(ur[c]) + 4'(ml[c]) + 4'(mr[c])
				+ 4'(dl[c]) + 4'(dn[c]) + 4'(dr[c]);
			nx[c] = (n == 4'd3) || ((n == 4'd2) && mid[c]);
		end
		return nx;
	endfunction

endpackage

>>> rtl/lae_dpath.sv
// Datapath of the life automaton engine: configuration registers, board memory
// with row valid bits, three-row window and the row rule. Uses lae_pkg.
module lae_dpath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lae_pkg::cmd_t             cmd,
	output lae_pkg::stat_t            stat,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [lae_pkg::CFG_W-1:0] cfg_data,
	input  logic [lae_pkg::COL_W-1:0] col,
	input  logic [lae_pkg::ROW_W-1:0] row,
	input  logic                      cell_in
);
	import lae_pkg::*;

	logic [CFG_W-1:0]    width_q, height_q;
	logic [CFG_W-1:0]    eff_w, eff_h;
	logic [MAX_COLS-1:0] cm;

	logic [MAX_COLS-1:0] board_q [MAX_ROWS];
	logic [MAX_ROWS-1:0] valid_q;
	logic [MAX_COLS-1:0] rdata_s1;
	logic                rvalid_s1;
	logic [ROW_W-1:0]    rrow_s1;
	logic [COL_W-1:0]    col_s1;
	logic                in_s1;

	logic [ROW_W-1:0]    raddr;
	logic                in_board;
	logic                cell_we;
	logic [MAX_COLS-1:0] cell_row;

	logic [MAX_COLS-1:0] up_q, mid_q, raw_mid_q;
	logic [MAX_COLS-1:0] raw_dn, dn_live, next_row;
	logic                diff;
	logic                changed_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_RST;
			height_q <= CFG_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IDX_WIDTH:  width_q  <= cfg_data;
				CFG_IDX_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp board size
	always_comb begin
		priority if (width_q < DIM_MIN) eff_w = DIM_MIN;
		else if (width_q > COLS_LIM)    eff_w = COLS_LIM;
		else                            eff_w = width_q;
		priority if (height_q < DIM_MIN) eff_h = DIM_MIN;
		else if (height_q > ROWS_LIM)    eff_h = ROWS_LIM;
		else                             eff_h = height_q;
	end

	// Interior column mask
	always_comb begin
		for (int c = 0; c < MAX_COLS; c++) begin
			cm[c] = (c != 0) && (CFG_W'(c) < (eff_w - CFG_W'(1)));
		end
	end

	function automatic logic row_in(input logic [ROW_W-1:0] r, input logic [CFG_W-1:0] h);
		return (r != '0) && ({{(CFG_W-ROW_W){1'b0}}, r} < (h - CFG_W'(1)));
	endfunction

	// Item address decode
	assign in_board = cm[col] && row_in(row, eff_h);
	assign cell_we  = cmd.cell_wr && in_board;
	assign cell_row = MAX_COLS'(cell_in) << col;
	assign raddr    = cmd.rd_sweep ? cmd.sweep_row : row;

	// Board memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		rdata_s1 <= board_q[raddr];
		if (cmd.wb_en) begin
			board_q[cmd.wb_row] <= next_row;
		end else if (cell_we) begin
			if (valid_q[row]) board_q[row][col] <= cell_in;
			else              board_q[row]      <= cell_row;
		end
	end

	// Row valid bits; an unwritten row reads as dead
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			rvalid_s1 <= valid_q[raddr];
			if (cmd.wb_en)    valid_q[cmd.wb_row] <= 1'b1;
			else if (cell_we) valid_q[row]        <= 1'b1;
		end
	end

	// Read-side payload tags
	always_ff @(posedge clk) begin
		rrow_s1 <= raddr;
		col_s1  <= col;
		in_s1   <= in_board;
	end

	// Lower neighbor as seen by the rule
	assign raw_dn  = rvalid_s1 ? rdata_s1 : '0;
	assign dn_live = (!cmd.dn_zero && row_in(rrow_s1, eff_h)) ? (raw_dn & cm) : '0;

	// New value of the middle row
	assign next_row = row_in(cmd.wb_row, eff_h) ? (life_next(up_q, mid_q, dn_live) & cm) : '0;
	assign diff     = next_row != raw_mid_q;

	// Three-row window
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			up_q      <= '0;
			mid_q     <= '0;
			raw_mid_q <= '0;
		end else if (cmd.shift) begin
			up_q      <= mid_q;
			mid_q     <= dn_live;
			raw_mid_q <= cmd.dn_zero ? '0 : raw_dn;
		end
	end

	// Change tracking over one generation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)                 changed_q <= 1'b0;
		else if (cmd.clear)          changed_q <= 1'b0;
		else if (cmd.wb_en && diff)  changed_q <= 1'b1;
	end

	assign stat.changed = changed_q || (cmd.wb_en && diff);
	assign stat.rd_cell = in_s1 && rvalid_s1 && rdata_s1[col_s1];

endmodule

>>> rtl/lae_ctrl.sv
// Controller of the life automaton engine: item acceptance, generation and
// row sweep sequencing, result strobe. Uses lae_pkg; drives lae_dpath.
module lae_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [1:0]                op,
	input  logic [lae_pkg::GEN_W-1:0] generations,
	output logic                      busy,
	output logic                      done,
	output logic                      cell_out,
	output logic [1:0]                op_done,
	output lae_pkg::cmd_t             cmd,
	input  lae_pkg::stat_t            stat
);
	import lae_pkg::*;

	state_t           state_q, state_d;
	logic [K_W-1:0]   k_q;
	logic [GEN_W-1:0] gens_q;
	logic             first_q;
	logic             done_q;
	op_t              op_q;

	logic             accept;
	logic             run_go;
	logic             sweeping;
	logic             gen_end;
	logic             run_stop;
	logic [K_W-1:0]   wb_k;

	assign accept   = start && (state_q == ST_IDLE);
	assign run_go   = accept && (op_t'(op) == OP_RUN) && (generations != '0);
	assign sweeping = state_q == ST_SWEEP;
	assign gen_end  = sweeping && (k_q == SWEEP_LAST);
	// A generation that changes nothing after the first one is a fixed point
	assign run_stop = gen_end && ((gens_q == GEN_W'(1)) || (!stat.changed && !first_q));
	assign wb_k     = k_q - K_W'(2);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (run_go)   state_d = ST_SWEEP;
			ST_SWEEP: if (run_stop) state_d = ST_IDLE;
			default:                state_d = ST_IDLE;
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd.rd_sweep  = sweeping;
		cmd.sweep_row = k_q[ROW_W-1:0];
		cmd.clear     = sweeping && (k_q == '0);
		cmd.shift     = sweeping && (k_q != '0);
		cmd.wb_en     = sweeping && (k_q >= K_W'(2));
		cmd.wb_row    = wb_k[ROW_W-1:0];
		cmd.dn_zero   = k_q == SWEEP_LAST;
		cmd.cell_wr   = accept && (op_t'(op) == OP_WRITE);
	end

	// State and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			op_q    <= OP_WRITE;
		end else begin
			state_q <= state_d;
			done_q  <= (accept && !run_go) || run_stop;
			if (accept) op_q <= op_t'(op);
		end
	end

	// Sweep counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			gens_q  <= '0;
			first_q <= 1'b0;
		end else if (run_go) begin
			k_q     <= '0;
			gens_q  <= generations;
			first_q <= 1'b1;
		end else if (gen_end) begin
			k_q     <= '0;
			gens_q  <= gens_q - GEN_W'(1);
			first_q <= 1'b0;
		end else if (sweeping) begin
			k_q     <= k_q + K_W'(1);
		end
	end

	assign busy     = sweeping;
	assign done     = done_q;
	assign op_done  = op_q;
	assign cell_out = done_q && (op_q == OP_READ) && stat.rd_cell;

endmodule

>>> rtl/life_automaton_engine_unit.sv
// Life automaton engine (B3/S23) on a 64 x 64 cell board.
// Top level: joins lae_ctrl and lae_dpath; uses lae_pkg.
//
// Usage:
//   An item is taken at a clock edge with start high and busy low. op selects
//   write cell (col, row, cell_in), run (generations) or read cell (col, row).
//   Every item returns one result: done is high for one cycle with op_done
//   echoing op and cell_out holding the cell for a read, zero otherwise.
//   Writes, reads and op three answer in the cycle after acceptance and busy
//   stays low, so one such item can be taken every cycle.
//   A run sweeps the board once per generation, one row per cycle through the
//   single board memory port, with busy high throughout and done in the cycle
//   after the last sweep. A run stops early once a generation after the first
//   leaves the board unchanged; zero generations answer in the cycle after
//   acceptance. Border cells are held dead.
//   cfg_we writes board_width (index 0) or board_height (index 1) from cfg_data
//   at the clock edge; write only while no item is in flight.
//   Reset clears the board (per-row valid bits, no clearing pass) and sets
//   both sizes to 64. The receiver cannot stall: done is never held off.
module life_automaton_engine_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                op,
	input  logic [lae_pkg::COL_W-1:0] col,
	input  logic [lae_pkg::ROW_W-1:0] row,
	input  logic                      cell_in,
	input  logic [lae_pkg::GEN_W-1:0] generations,
	output logic                      done,
	output logic                      cell_out,
	output logic [1:0]                op_done,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [lae_pkg::CFG_W-1:0] cfg_data
);
	import lae_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// Sequencer
	lae_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.op          (op),
		.generations (generations),
		.busy        (busy),
		.done        (done),
		.cell_out    (cell_out),
		.op_done     (op_done),
		.cmd         (cmd),
		.stat        (stat)
	);

	// Board storage and rule
	lae_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.col       (col),
		.row       (row),
		.cell_in   (cell_in)
	);

endmodule

>>> tb/testbench.sv
// Self-checking testbench for life_automaton_engine_unit: cell writes, B3/S23 runs and reads.
// A scoreboard class keeps its own copy of the board and the size registers.
// Depends on lae_pkg and the RTL of life_automaton_engine_unit.
import lae_pkg::*;

typedef bit [MAX_ROWS-1:0][MAX_COLS-1:0] grid_t;

typedef struct {
	bit  cell_val;
	op_t opc;
} cell_result_t;

// Board predictor and result scoreboard
class life_scoreboard;
	grid_t        cells;
	bit [6:0]     width_reg;
	bit [6:0]     height_reg;
	int           wid;
	int           hgt;
	bit [63:0]    colmask;
	cell_result_t pending_results[$];
	int           mismatches;

	function new();
		cells      = '0;
		width_reg  = 7'd64;
		height_reg = 7'd64;
		mismatches = 0;
		resize();
	endfunction

	// Clamp the size registers and rebuild the interior column mask
	function void resize();
		wid = width_reg;
		hgt = height_reg;
		if (wid < 3) wid = 3;
		if (wid > MAX_COLS) wid = MAX_COLS;
		if (hgt < 3) hgt = 3;
		if (hgt > MAX_ROWS) hgt = MAX_ROWS;
		colmask = '0;
		for (int c = 1; c < wid - 1; c++) colmask[c] = 1'b1;
	endfunction

	function void write_reg(logic idx, bit [6:0] v);
		if (idx == CFG_IDX_WIDTH) width_reg = v;
		else height_reg = v;
		resize();
	endfunction

	function bit on_board(int c, int r);
		return colmask[c] && r >= 1 && r + 2 <= hgt;
	endfunction

	// Row as the rule sees it: border and outside cells are dead
	function bit [63:0] live(grid_t g, int r);
		if (r < 1 || r + 2 > hgt) return '0;
		return g[r] & colmask;
	endfunction

	// One B3/S23 generation; every cell that is not interior comes out dead
	function grid_t next_board(grid_t g);
		grid_t     nb;
		bit [63:0] up, mid, dn;
		int        cnt;
		nb = '0;
		for (int r = 1; r + 2 <= hgt; r++) begin
			up  = live(g, r - 1);
			mid = live(g, r);
			dn  = live(g, r + 1);
			for (int c = 1; c < MAX_COLS - 1; c++) begin
				if (colmask[c]) begin
					cnt = int'(up[c-1]) + int'(up[c]) + int'(up[c+1]) + int'(mid[c-1])
						+ int'(mid[c+1]) + int'(dn[c-1]) + int'(dn[c]) + int'(dn[c+1]);
					nb[r][c] = (cnt == 3) || (cnt == 2 && mid[c]);
				end
			end
		end
		return nb;
	endfunction

	// Advance up to gens generations (at most cap); a generation after the first
	// that changes nothing ends the run. Returns the generations swept.
	function int play(int gens, int cap, bit commit);
		grid_t g, nx;
		int    n;
		bit    same;
		g = cells;
		n = 0;
		for (int k = 0; k < gens && k < cap; k++) begin
			nx   = next_board(g);
			same = (nx == g);
			g    = nx;
			n++;
			if (same && k > 0) break;
		end
		if (commit) cells = g;
		return n;
	endfunction

	// Accepted item: update the board and queue the result it must produce
	function void note(op_t o, int c, int r, bit v, int gens);
		cell_result_t e;
		e.cell_val = 1'b0;
		e.opc      = o;
		case (o)
			OP_WRITE: begin
				if (on_board(c, r)) cells[r][c] = v;
			end
			OP_RUN: begin
				void'(play(gens, gens, 1'b1));
			end
			OP_READ: begin
				if (on_board(c, r)) e.cell_val = cells[r][c];
			end
			default: ;
		endcase
		pending_results.push_back(e);
	endfunction

	function void report(string msg);
		$display("MISMATCH: %s", msg);
		mismatches++;
	endfunction

	// Compare one strobed result with the oldest expectation
	function void check(bit cval, bit [1:0] opc);
		cell_result_t e;
		if (pending_results.size() == 0) begin
			report($sformatf("unexpected result op_done=%0d cell_out=%0d", opc, cval));
			return;
		end
		e = pending_results.pop_front();
		if (opc != e.opc)
			report($sformatf("op_done=%0d, want %0d", opc, e.opc));
		if (cval != e.cell_val)
			report($sformatf("cell_out=%0d, want %0d (op %0d)", cval, e.cell_val, e.opc));
	endfunction
endclass

module testbench;
	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	op_t         op;
	logic [5:0]  col;
	logic [5:0]  row;
	logic        cell_in;
	logic [15:0] generations;
	logic        done;
	logic        cell_out;
	logic [1:0]  op_done;
	logic        cfg_we;
	logic        cfg_index;
	logic [6:0]  cfg_data;

	life_scoreboard board;

	life_automaton_engine_unit u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op), .col(col),
		.row(row), .cell_in(cell_in), .generations(generations), .done(done),
		.cell_out(cell_out), .op_done(op_done), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result monitor: done is a one-cycle strobe, sampled at the closing edge
	always @(posedge clk) begin
		if (arst_n && done) board.check(cell_out, op_done);
	end

	// Present one item and hold it until the block takes it
	task automatic issue(op_t o, bit [5:0] c, bit [5:0] r, bit v, bit [15:0] g);
		start       <= 1'b1;
		op          <= o;
		col         <= c;
		row         <= r;
		cell_in     <= v;
		generations <= g;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note(o, c, r, v, g);
	endtask

	// Sender gap: start low, junk on the item fields
	task automatic idle(int n);
		repeat (n) begin
			start       <= 1'b0;
			op          <= op_t'(2'($urandom_range(0, 3)));
			col         <= 6'($urandom);
			row         <= 6'($urandom);
			cell_in     <= 1'($urandom);
			generations <= 16'($urandom);
			@(posedge clk);
		end
	endtask

	// Wait until every queued result has come back
	task automatic drain();
		start <= 1'b0;
		while (board.pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_cfg(logic idx, bit [6:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		board.write_reg(idx, v);
	endtask

	task automatic set_size(bit [6:0] w, bit [6:0] h);
		drain();
		write_cfg(CFG_IDX_WIDTH, w);
		write_cfg(CFG_IDX_HEIGHT, h);
		cfg_we <= 1'b0;
	endtask

	// Address mix: anywhere, within the board in use, or a corner cluster
	function automatic int pick_coord(int lim);
		int k;
		k = $urandom_range(0, 9);
		if (k < 2) return $urandom_range(0, 63);
		if (k < 6) return $urandom_range(0, lim - 1);
		return $urandom_range(0, (lim < 10) ? lim - 1 : 9);
	endfunction

	// Long runs only where the board settles quickly
	function automatic int pick_gens();
		int k, g;
		k = $urandom_range(0, 99);
		if (k < 10) return 0;
		if (k < 70) return $urandom_range(1, 3);
		if (k < 90) return $urandom_range(4, 12);
		g = $urandom_range(0, 65535);
		if (board.play(g, 20, 1'b0) >= 20) g = $urandom_range(4, 12);
		return g;
	endfunction

	task automatic random_item();
		int  k, g;
		op_t o;
		k = $urandom_range(0, 99);
		g = 16'($urandom);
		if (k < 45) o = OP_WRITE;
		else if (k < 80) o = OP_READ;
		else if (k < 95) o = OP_RUN;
		else o = OP_NOP;
		if (o == OP_RUN) g = pick_gens();
		issue(o, 6'(pick_coord(board.wid)), 6'(pick_coord(board.hgt)),
			$urandom_range(0, 9) < 6, 16'(g));
	endtask

	initial begin
		bit [6:0] sizes[6][2];
		int       burst;
		sizes = '{'{7'd3, 7'd3}, '{7'd0, 7'd127}, '{7'd127, 7'd0}, '{7'd10, 7'd8},
			'{7'd64, 7'd64}, '{7'd2, 7'd65}};
		board       = new();
		arst_n      <= 1'b0;
		start       <= 1'b0;
		op          <= OP_WRITE;
		col         <= '0;
		row         <= '0;
		cell_in     <= 1'b0;
		generations <= '0;
		cfg_we      <= 1'b0;
		cfg_index   <= CFG_IDX_WIDTH;
		cfg_data    <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: corners of the interior, border writes, op three, zero and
		// maximum generation counts, then a blinker
		issue(OP_READ, 6'd30, 6'd30, 1'b0, 16'd0);
		issue(OP_WRITE, 6'd1, 6'd1, 1'b1, 16'd0);
		issue(OP_WRITE, 6'd62, 6'd62, 1'b1, 16'hffff);
		issue(OP_WRITE, 6'd0, 6'd5, 1'b1, 16'd0);
		issue(OP_WRITE, 6'd63, 6'd63, 1'b1, 16'd0);
		issue(OP_READ, 6'd1, 6'd1, 1'b0, 16'd0);
		issue(OP_READ, 6'd62, 6'd62, 1'b1, 16'd0);
		issue(OP_READ, 6'd0, 6'd5, 1'b0, 16'd0);
		issue(OP_READ, 6'd63, 6'd63, 1'b0, 16'd0);
		issue(OP_NOP, 6'd63, 6'd63, 1'b1, 16'hffff);
		issue(OP_RUN, 6'd0, 6'd0, 1'b0, 16'd0);
		issue(OP_READ, 6'd1, 6'd1, 1'b0, 16'd0);
		issue(OP_RUN, 6'd63, 6'd63, 1'b1, 16'hffff);
		issue(OP_READ, 6'd62, 6'd62, 1'b0, 16'd0);
		issue(OP_WRITE, 6'd10, 6'd10, 1'b1, 16'd0);
		issue(OP_WRITE, 6'd11, 6'd10, 1'b1, 16'd0);
		issue(OP_WRITE, 6'd12, 6'd10, 1'b1, 16'd0);
		issue(OP_RUN, 6'd0, 6'd0, 1'b0, 16'd1);
		issue(OP_READ, 6'd11, 6'd9, 1'b0, 16'd0);
		issue(OP_READ, 6'd10, 6'd10, 1'b0, 16'd0);
		issue(OP_RUN, 6'd0, 6'd0, 1'b0, 16'd2);
		issue(OP_READ, 6'd12, 6'd10, 1'b0, 16'd0);
		issue(OP_WRITE, 6'd11, 6'd10, 1'b0, 16'd0);
		issue(OP_READ, 6'd11, 6'd10, 1'b0, 16'd0);

		// Random phases, each under its own board size, sender in bursts
		for (int p = 0; p < 8; p++) begin
			if (p < 6) set_size(sizes[p][0], sizes[p][1]);
			else set_size(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
			burst = $urandom_range(1, 24);
			for (int i = 0; i < 100; i++) begin
				random_item();
				burst = burst - 1;
				if (burst == 0) begin
					if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 8));
					burst = $urandom_range(1, 24);
				end
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (board.mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Run limit, far above the slowest correct run
	initial begin
		#20_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

>>> sim.f
rtl/lae_pkg.sv
rtl/lae_dpath.sv
rtl/lae_ctrl.sv
rtl/life_automaton_engine_unit.sv
tb/testbench.sv
